FILE: hw/rtl/brd_pkg.sv
// shared types and constants for the byte-run decoder
package brd_pkg;

   localparam int COUNT_BITS = 32;
   localparam int DATA_BITS = 8;
   localparam int DIM_BITS = 16;
   localparam int PLANE_BITS = 6;
   localparam int WORD_BITS = DIM_BITS - 3;
   localparam int PROD_BITS = WORD_BITS + DIM_BITS;
   localparam int LIMIT_BITS = PROD_BITS + PLANE_BITS + 1;
   localparam int REM_BITS = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = DIM_BITS;

   localparam logic [DATA_BITS-1:0] BAD_HEADER = 8'h80;
   localparam logic [DATA_BITS:0] REPEAT_BASE = 9'd257;

   localparam logic RESET_MODE = 1'b1;
   localparam logic [DIM_BITS-1:0] RESET_WIDTH = 16'd320;
   localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 16'd200;
   localparam logic [PLANE_BITS-1:0] RESET_PLANES = 6'd5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COMPRESS_MODE = 2'd0,
      CSR_IMAGE_WIDTH   = 2'd1,
      CSR_IMAGE_HEIGHT  = 2'd2,
      CSR_PLANE_COUNT   = 2'd3
   } brd_csr_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_HEADER = 2'd1,
      ST_OVERFLOW   = 2'd2,
      ST_OPEN_RUN   = 2'd3
   } brd_status_type;

   typedef struct packed {
      logic                  mode;
      logic                  busy;
      logic [LIMIT_BITS-1:0] limit;
   } brd_cfg_type;

   typedef struct packed {
      logic step;
      logic clear;
   } brd_keep_ctl_type;

endpackage

FILE: hw/rtl/brd_ifs.sv
// valid/ready channel interfaces for body words and decoded result words
interface brd_req_if;
   logic                           valid;
   logic                           ready;
   logic [brd_pkg::DATA_BITS-1:0]  body_byte;
   logic                           end_of_body;

   modport source(output valid, body_byte, end_of_body, input ready);
   modport sink(input valid, body_byte, end_of_body, output ready);
endinterface

interface brd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [brd_pkg::DATA_BITS-1:0]  first_byte;
   logic [brd_pkg::DATA_BITS-1:0]  second_byte;
   logic [1:0]                     byte_count;
   logic                           run_last;
   logic [1:0]                     status;

   modport source(output valid, first_byte, second_byte, byte_count, run_last, status,
                  input ready);
   modport sink(input valid, first_byte, second_byte, byte_count, run_last, status,
                output ready);
endinterface

FILE: hw/rtl/brd_config.sv
// configuration registers and two-stage output size limit pipeline
module brd_config (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [brd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [brd_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   output brd_pkg::brd_cfg_type                cfg
);

   logic                            mode_ff, mode_in;
   logic [brd_pkg::DIM_BITS-1:0]    width_ff, width_in;
   logic [brd_pkg::DIM_BITS-1:0]    height_ff, height_in;
   logic [brd_pkg::PLANE_BITS-1:0]  planes_ff, planes_in;
   logic [1:0]                      pend_ff, pend_in;
   logic [brd_pkg::WORD_BITS-1:0]   words;
   logic [brd_pkg::PROD_BITS-1:0]   prod_ff, prod_in;
   logic [brd_pkg::LIMIT_BITS-1:0]  limit_ff, limit_in;

   always_comb begin
      mode_in = mode_ff;
      width_in = width_ff;
      height_in = height_ff;
      planes_in = planes_ff;
      pend_in = (pend_ff != 2'd0) ? 2'(pend_ff - 2'd1) : pend_ff;
      if (csr_wr_en) begin
         pend_in = 2'd2;
         unique case (csr_index)
            brd_pkg::CSR_COMPRESS_MODE: mode_in = csr_wr_data[0];
            brd_pkg::CSR_IMAGE_WIDTH:   width_in = csr_wr_data;
            brd_pkg::CSR_IMAGE_HEIGHT:  height_in = csr_wr_data;
            brd_pkg::CSR_PLANE_COUNT:   planes_in = csr_wr_data[brd_pkg::PLANE_BITS-1:0];
         endcase
      end
   end

   // 16-pixel words per row, then rows, then planes, two bytes per word
   assign words = brd_pkg::WORD_BITS'(
      ({1'b0, width_ff} + (brd_pkg::DIM_BITS+1)'(15)) >> 4);
   assign prod_in = brd_pkg::PROD_BITS'(words * height_ff);
   assign limit_in = {(brd_pkg::LIMIT_BITS-1)'(prod_ff * planes_ff), 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= brd_pkg::RESET_MODE;
         width_ff <= brd_pkg::RESET_WIDTH;
         height_ff <= brd_pkg::RESET_HEIGHT;
         planes_ff <= brd_pkg::RESET_PLANES;
         pend_ff <= 2'd2;
      end else begin
         mode_ff <= mode_in;
         width_ff <= width_in;
         height_ff <= height_in;
         planes_ff <= planes_in;
         pend_ff <= pend_in;
      end
      prod_ff <= prod_in;
      limit_ff <= limit_in;
   end

   assign cfg.mode = mode_ff;
   assign cfg.busy = (pend_ff != 2'd0) || csr_wr_en;
   assign cfg.limit = limit_ff;

endmodule

FILE: hw/rtl/brd_keep_unit.sv
// shared byte counter with limit compare and saturating increment
module brd_keep_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  brd_pkg::brd_keep_ctl_type         ctl,
   input  logic [brd_pkg::LIMIT_BITS-1:0]    limit,
   output logic                              keep
);

   localparam int CMP_BITS = (brd_pkg::COUNT_BITS > brd_pkg::LIMIT_BITS) ?
                             brd_pkg::COUNT_BITS : brd_pkg::LIMIT_BITS;

   logic [brd_pkg::COUNT_BITS-1:0] count_ff, count_in;

   assign keep = CMP_BITS'(count_ff) < CMP_BITS'(limit);

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.step && keep && (count_ff != '1)) begin
         count_in = brd_pkg::COUNT_BITS'(count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: hw/rtl/brd_sequencer.sv
// run sequencer: header parse, literal copy, repeat expansion and result register
module brd_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   brd_req_if.sink                         req,
   brd_rsp_if.source                       rsp,
   input  brd_pkg::brd_cfg_type            cfg,
   input  logic                            keep,
   output brd_pkg::brd_keep_ctl_type       keep_ctl
);

   typedef enum logic [2:0] {
      S_IDLE, S_PASS, S_BAD, S_LIT, S_REP1, S_REP2, S_TAIL
   } state_type;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LITERAL = 2'd1,
      PH_REPEAT  = 2'd2
   } phase_type;

   state_type                        state_ff, state_in;
   phase_type                        phase_ff, phase_in;
   logic [brd_pkg::REM_BITS-1:0]     rem_ff, rem_in;
   logic [brd_pkg::DATA_BITS-1:0]    byte_ff, byte_in;
   logic                             end_ff, end_in;
   logic                             got0_ff, got0_in;
   logic                             valid_ff, valid_in;
   logic [brd_pkg::DATA_BITS-1:0]    first_ff, first_in;
   logic [brd_pkg::DATA_BITS-1:0]    second_ff, second_in;
   logic [1:0]                       count_ff, count_in;
   logic                             last_ff, last_in;
   logic [1:0]                       status_ff, status_in;

   logic                             out_free;
   logic                             accept;
   logic [brd_pkg::REM_BITS-1:0]     rem_dec;
   logic                             open_run;
   logic [1:0]                       got;

   assign req.ready = (state_ff == S_IDLE) && !cfg.busy;
   assign accept = req.valid && req.ready;
   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rem_in = rem_ff;
      byte_in = byte_ff;
      end_in = end_ff;
      got0_in = got0_ff;
      valid_in = valid_ff && !rsp.ready;
      first_in = first_ff;
      second_in = second_ff;
      count_in = count_ff;
      last_in = last_ff;
      status_in = status_ff;
      keep_ctl = '0;
      rem_dec = '0;
      open_run = 1'b0;
      got = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in = req.body_byte;
               end_in = req.end_of_body;
               if (!cfg.mode) begin
                  state_in = S_PASS;
               end else begin
                  unique case (phase_ff)
                     PH_LITERAL: state_in = S_LIT;
                     PH_REPEAT:  state_in = S_REP1;
                     default: begin
                        if (req.body_byte == brd_pkg::BAD_HEADER) begin
                           state_in = S_BAD;
                        end else begin
                           if (!req.body_byte[brd_pkg::DATA_BITS-1]) begin
                              phase_in = PH_LITERAL;
                              rem_in = brd_pkg::REM_BITS'(req.body_byte + 1'b1);
                           end else begin
                              phase_in = PH_REPEAT;
                              rem_in = brd_pkg::REM_BITS'(
                                 brd_pkg::REPEAT_BASE - {1'b0, req.body_byte});
                           end
                           if (req.end_of_body) begin
                              state_in = S_TAIL;
                           end
                        end
                     end
                  endcase
               end
            end
         end
         S_PASS: begin
            if (out_free) begin
               valid_in = 1'b1;
               first_in = byte_ff;
               second_in = '0;
               count_in = 2'd1;
               last_in = 1'b1;
               status_in = brd_pkg::ST_OK;
               if (end_ff) begin
                  phase_in = PH_HEADER;
                  rem_in = '0;
                  keep_ctl.clear = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_BAD: begin
            if (out_free) begin
               valid_in = 1'b1;
               first_in = '0;
               second_in = '0;
               count_in = 2'd0;
               last_in = 1'b1;
               status_in = brd_pkg::ST_BAD_HEADER;
               if (end_ff) begin
                  keep_ctl.clear = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_LIT: begin
            if (out_free) begin
               keep_ctl.step = 1'b1;
               rem_dec = brd_pkg::REM_BITS'(rem_ff - 1'b1);
               open_run = rem_dec != '0;
               valid_in = 1'b1;
               first_in = keep ? byte_ff : '0;
               second_in = '0;
               count_in = {1'b0, keep};
               last_in = !(end_ff && open_run);
               status_in = keep ? brd_pkg::ST_OK : brd_pkg::ST_OVERFLOW;
               rem_in = rem_dec;
               if (!open_run) begin
                  phase_in = PH_HEADER;
               end
               if (end_ff && open_run) begin
                  state_in = S_TAIL;
               end else begin
                  if (end_ff) begin
                     keep_ctl.clear = 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_REP1: begin
            if (rem_ff[brd_pkg::REM_BITS-1:1] != '0) begin
               keep_ctl.step = 1'b1;
               got0_in = keep;
               state_in = S_REP2;
            end else if (out_free) begin
               keep_ctl.step = 1'b1;
               valid_in = 1'b1;
               first_in = keep ? byte_ff : '0;
               second_in = '0;
               count_in = {1'b0, keep};
               last_in = 1'b1;
               status_in = keep ? brd_pkg::ST_OK : brd_pkg::ST_OVERFLOW;
               phase_in = PH_HEADER;
               rem_in = '0;
               if (end_ff) begin
                  keep_ctl.clear = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_REP2: begin
            if (out_free) begin
               keep_ctl.step = 1'b1;
               got = {1'b0, got0_ff} + {1'b0, keep};
               rem_dec = brd_pkg::REM_BITS'(rem_ff - 2'd2);
               valid_in = 1'b1;
               first_in = (got != 2'd0) ? byte_ff : '0;
               second_in = (got == 2'd2) ? byte_ff : '0;
               count_in = got;
               last_in = rem_dec == '0;
               status_in = (got == 2'd2) ? brd_pkg::ST_OK : brd_pkg::ST_OVERFLOW;
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_HEADER;
                  if (end_ff) begin
                     keep_ctl.clear = 1'b1;
                  end
                  state_in = S_IDLE;
               end else begin
                  state_in = S_REP1;
               end
            end
         end
         S_TAIL: begin
            if (out_free) begin
               valid_in = 1'b1;
               first_in = '0;
               second_in = '0;
               count_in = 2'd0;
               last_in = 1'b1;
               status_in = brd_pkg::ST_OPEN_RUN;
               phase_in = PH_HEADER;
               rem_in = '0;
               keep_ctl.clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_HEADER;
         rem_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rem_ff <= rem_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      end_ff <= end_in;
      got0_ff <= got0_in;
      first_ff <= first_in;
      second_ff <= second_in;
      count_ff <= count_in;
      last_ff <= last_in;
      status_ff <= status_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.first_byte = first_ff;
   assign rsp.second_byte = second_ff;
   assign rsp.byte_count = count_ff;
   assign rsp.run_last = last_ff;
   assign rsp.status = status_ff;

endmodule

FILE: hw/rtl/byterun_rle_decoder.sv
// top level of the byte-run (packbits) image body decoder
// Body bytes enter on req one word at a time; decoded bytes leave on rsp in
// words of up to two bytes, with a status code per word. A run header that
// opens a literal or repeat run makes no result. A literal byte, a pass-mode
// byte, a bad header or a run header that ends the body each make one result
// word; a literal byte that ends the body with its run still open makes a
// second word with the open-run status. A repeat byte of an n-long run is
// expanded by a single shared counter-and-limit-compare unit that decides
// whether each byte is kept, one byte per cycle while rsp takes results; it
// yields ceil(n/2) result words. While rsp holds back a full result register
// and a new result is due, the decoder stalls. After any csr write, req is
// held not ready while the output size limit is recomputed through a
// two-stage multiply pipeline; the same wait follows reset.
module byterun_rle_decoder (
   input  logic                                clock,
   input  logic                                reset,
   brd_req_if.sink                             req,
   brd_rsp_if.source                           rsp,
   input  logic                                csr_wr_en,
   input  logic [brd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [brd_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);

   brd_pkg::brd_cfg_type       cfg;
   brd_pkg::brd_keep_ctl_type  keep_ctl;
   logic                       keep;

   brd_config u_config (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   brd_keep_unit u_keep (
      .clock (clock),
      .reset (reset),
      .ctl   (keep_ctl),
      .limit (cfg.limit),
      .keep  (keep)
   );

   brd_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .cfg      (cfg),
      .keep     (keep),
      .keep_ctl (keep_ctl)
   );

endmodule
